@@ src/rucl_pkg.sv @@
// ----------------------------------------------------------------------------
// rucl_pkg
// Types, codes and reset values shared by the room use classifier modules.
// ----------------------------------------------------------------------------
`default_nettype none

package rucl_pkg;

  typedef enum logic [4:0] {
    MODE_IDLE   = 5'b00001,
    MODE_DETECT = 5'b00010,
    MODE_SHORT  = 5'b00100,
    MODE_LONG   = 5'b01000,
    MODE_CLEAN  = 5'b10000
  } mode_e;

  localparam logic [2:0] ROOM_IDLE   = 3'd0;
  localparam logic [2:0] ROOM_DETECT = 3'd1;
  localparam logic [2:0] ROOM_SHORT  = 3'd2;
  localparam logic [2:0] ROOM_LONG   = 3'd3;
  localparam logic [2:0] ROOM_CLEAN  = 3'd4;

  localparam logic [1:0] LED_OFF        = 2'd0;
  localparam logic [1:0] LED_ON         = 2'd1;
  localparam logic [1:0] LED_SLOW_BLINK = 2'd2;
  localparam logic [1:0] LED_FAST_BLINK = 2'd3;

  localparam logic [2:0] REG_DETECT_TIMEOUT = 3'd0;
  localparam logic [2:0] REG_SHORT_SIT      = 3'd1;
  localparam logic [2:0] REG_LONG_SIT       = 3'd2;
  localparam logic [2:0] REG_CLEAN_COUNT    = 3'd3;
  localparam logic [2:0] REG_SHORT_SPRAYS   = 3'd4;
  localparam logic [2:0] REG_LONG_SPRAYS    = 3'd5;
  localparam logic [2:0] REG_SHORT_DELAY    = 3'd6;
  localparam logic [2:0] REG_LONG_DELAY     = 3'd7;

  localparam logic [31:0] RST_DETECT_TIMEOUT = 32'd180000;
  localparam logic [31:0] RST_SHORT_SIT      = 32'd10000;
  localparam logic [31:0] RST_LONG_SIT       = 32'd100000;
  localparam logic [7:0]  RST_CLEAN_COUNT    = 8'd12;

  typedef struct packed {
    logic [31:0] detect_timeout_ms;
    logic [31:0] short_sit_ms;
    logic [31:0] long_sit_ms;
    logic [7:0]  cleaning_motion_count;
    logic [7:0]  short_spray_count;
    logic [7:0]  long_spray_count;
    logic [31:0] short_spray_delay_ms;
    logic [31:0] long_spray_delay_ms;
  } cfg_t;

  typedef struct packed {
    logic [31:0] time_ms;
    logic        motion_seen;
    logic        seat_occupied;
    logic        light_on;
    logic        door_closed;
    logic [7:0]  motion_count;
  } tick_t;

  typedef struct packed {
    logic [2:0]  room_state;
    logic [1:0]  green_led_mode;
    logic        spray_request;
    logic [7:0]  spray_count;
    logic [31:0] spray_delay_ms;
    logic        cancel_sprays;
    logic        wake_screen;
    logic        clear_motion_count;
  } result_t;

  function automatic logic [2:0] room_code(input mode_e m);
    logic [2:0] code;
    unique case (m)
      MODE_IDLE:   code = ROOM_IDLE;
      MODE_DETECT: code = ROOM_DETECT;
      MODE_SHORT:  code = ROOM_SHORT;
      MODE_LONG:   code = ROOM_LONG;
      MODE_CLEAN:  code = ROOM_CLEAN;
      default:     code = ROOM_IDLE;
    endcase
    return code;
  endfunction

endpackage

`default_nettype wire

@@ src/rucl_core.sv @@
// ----------------------------------------------------------------------------
// rucl_core
// Visit state machine: holds the mode and sitting bookkeeping, and forms the
// result of one tick from the registered tick and the current state.
// ----------------------------------------------------------------------------
`default_nettype none

module rucl_core
  import rucl_pkg::*;
(
  input  wire logic    clk_i,
  input  wire logic    rst_ni,
  input  wire logic    step_i,
  input  wire tick_t   tick_i,
  input  wire cfg_t    cfg_i,
  output result_t      res_o
);

  mode_e       mode_q, mode_d;
  logic [31:0] entry_q, entry_d;
  logic [31:0] sit_start_q, sit_start_d;
  logic [31:0] longest_q, longest_d;
  logic        seated_q, seated_d;
  logic        left_q, left_d;
  logic        door_sit_q, door_sit_d;
  logic [1:0]  led_q, led_d;

  logic        go;
  mode_e       target;
  logic [31:0] sit_dur;
  logic [31:0] elapsed;
  logic        spray;
  logic [7:0]  scount;
  logic [31:0] sdelay;
  logic        pulse_cancel, pulse_wake, pulse_clear;

  assign sit_dur = tick_i.time_ms - sit_start_q;
  assign elapsed = tick_i.time_ms - entry_q;

  always_comb begin
    mode_d       = mode_q;
    entry_d      = entry_q;
    sit_start_d  = sit_start_q;
    longest_d    = longest_q;
    seated_d     = seated_q;
    left_d       = left_q;
    door_sit_d   = door_sit_q;
    led_d        = led_q;
    go           = 1'b0;
    target       = mode_q;
    spray        = 1'b0;
    scount       = '0;
    sdelay       = '0;
    pulse_cancel = 1'b0;
    pulse_wake   = 1'b0;
    pulse_clear  = 1'b0;

    unique case (mode_q)
      MODE_IDLE: begin
        if (tick_i.motion_seen && (tick_i.light_on || !tick_i.door_closed)) begin
          go     = 1'b1;
          target = MODE_DETECT;
        end
      end
      MODE_DETECT: begin
        if (!seated_q && tick_i.seat_occupied) begin
          left_d      = 1'b0;
          sit_start_d = tick_i.time_ms;
          seated_d    = 1'b1;
          door_sit_d  = tick_i.door_closed;
        end
        if (seated_q && !tick_i.seat_occupied) begin
          left_d   = 1'b1;
          seated_d = 1'b0;
          if (sit_dur > longest_q) begin
            longest_d = sit_dur;
          end
        end
        if ((!tick_i.light_on && !tick_i.motion_seen && left_d) ||
            (elapsed >= cfg_i.detect_timeout_ms)) begin
          go = 1'b1;
          if (tick_i.motion_count >= cfg_i.cleaning_motion_count && !door_sit_d) begin
            target = MODE_CLEAN;
          end else if (longest_d < cfg_i.long_sit_ms && longest_d > cfg_i.short_sit_ms) begin
            target = MODE_SHORT;
          end else if (longest_d > cfg_i.long_sit_ms) begin
            target = MODE_LONG;
          end else begin
            target = MODE_IDLE;
          end
        end
      end
      MODE_SHORT, MODE_LONG, MODE_CLEAN: begin
        if (!tick_i.motion_seen && !tick_i.seat_occupied &&
            (!tick_i.light_on || tick_i.door_closed)) begin
          go     = 1'b1;
          target = MODE_IDLE;
          if (mode_q == MODE_SHORT) begin
            spray  = 1'b1;
            scount = cfg_i.short_spray_count;
            sdelay = cfg_i.short_spray_delay_ms;
          end else if (mode_q == MODE_LONG) begin
            spray  = 1'b1;
            scount = cfg_i.long_spray_count;
            sdelay = cfg_i.long_spray_delay_ms;
          end
        end
      end
      default: ;
    endcase

    if (go && (target != mode_q)) begin
      mode_d  = target;
      entry_d = tick_i.time_ms;
      unique case (target)
        MODE_IDLE: begin
          pulse_clear = 1'b1;
          seated_d    = 1'b0;
          longest_d   = '0;
          left_d      = 1'b0;
          door_sit_d  = 1'b0;
          led_d       = LED_SLOW_BLINK;
        end
        MODE_DETECT: begin
          led_d        = LED_FAST_BLINK;
          pulse_cancel = 1'b1;
          pulse_wake   = 1'b1;
        end
        MODE_SHORT, MODE_LONG: begin
          led_d = LED_OFF;
        end
        default: begin
          led_d = LED_ON;
        end
      endcase
    end
  end

  always_comb begin
    res_o.room_state         = room_code(mode_d);
    res_o.green_led_mode     = led_d;
    res_o.spray_request      = spray;
    res_o.spray_count        = scount;
    res_o.spray_delay_ms     = sdelay;
    res_o.cancel_sprays      = pulse_cancel;
    res_o.wake_screen        = pulse_wake;
    res_o.clear_motion_count = pulse_clear;
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      mode_q      <= MODE_IDLE;
      entry_q     <= '0;
      sit_start_q <= '0;
      longest_q   <= '0;
      seated_q    <= 1'b0;
      left_q      <= 1'b0;
      door_sit_q  <= 1'b0;
      led_q       <= LED_SLOW_BLINK;
    end else if (step_i) begin
      mode_q      <= mode_d;
      entry_q     <= entry_d;
      sit_start_q <= sit_start_d;
      longest_q   <= longest_d;
      seated_q    <= seated_d;
      left_q      <= left_d;
      door_sit_q  <= door_sit_d;
      led_q       <= led_d;
    end
  end

endmodule

`default_nettype wire

@@ src/room_use_classifier_top.sv @@
// ----------------------------------------------------------------------------
// room_use_classifier_top
// Classifies a room visit from sensor ticks and reports state, LED mode and
// spray, screen and motion-count pulses, one result per tick.
// ----------------------------------------------------------------------------
// Usage:
//   s_axis carries one sensor tick per transaction; m_axis returns exactly one
//   result per tick, in order. The APB port holds eight registers at byte
//   addresses 4*i; write them only while no tick is in flight.
//   A tick is captured in an input register at acceptance and its result
//   lands in the output register on the next edge that the output is free,
//   which raises m_axis_tvalid; the receiver can take it from then on.
//   Throughput is one tick per cycle while the receiver holds m_axis_tready
//   high: the input register and the output register form a two-entry
//   pipeline; the visit state updates as a tick moves between the two.
//   When the receiver stalls, the output holds and the input register takes
//   one more tick before s_axis_tready falls.
//   Reset clears both pipeline entries, returns the machine to idle with
//   slow-blink LED, and restores the register reset values.
// ----------------------------------------------------------------------------
`default_nettype none

module room_use_classifier_top
  import rucl_pkg::*;
(
  input  wire logic        clk_i,
  input  wire logic        rst_ni,
  // tdata: time_ms[31:0], motion_seen[32], seat_occupied[33], light_on[34],
  //        door_closed[35], motion_count[43:36], zero[47:44]
  input  wire logic        s_axis_tvalid,
  output logic             s_axis_tready,
  input  wire logic [47:0] s_axis_tdata,
  // tdata: room_state[2:0], green_led_mode[4:3], spray_request[5],
  //        spray_count[13:6], spray_delay_ms[45:14], cancel_sprays[46],
  //        wake_screen[47], clear_motion_count[48], zero[55:49]
  output logic             m_axis_tvalid,
  input  wire logic        m_axis_tready,
  output logic [55:0]      m_axis_tdata,
  input  wire logic        psel,
  input  wire logic        penable,
  input  wire logic        pwrite,
  input  wire logic [4:0]  paddr,
  input  wire logic [31:0] pwdata,
  output logic [31:0]      prdata,
  output logic             pready
);

  cfg_t        cfg_q;
  logic        in_valid_q;
  tick_t       in_tick_q;
  logic        out_valid_q;
  result_t     out_res_q;
  result_t     res;
  logic        advance;
  logic        cfg_wr;
  logic [2:0]  reg_idx;

  // configuration
  assign pready  = 1'b1;
  assign cfg_wr  = psel && penable && pwrite;
  assign reg_idx = paddr[4:2];

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      cfg_q.detect_timeout_ms     <= RST_DETECT_TIMEOUT;
      cfg_q.short_sit_ms          <= RST_SHORT_SIT;
      cfg_q.long_sit_ms           <= RST_LONG_SIT;
      cfg_q.cleaning_motion_count <= RST_CLEAN_COUNT;
      cfg_q.short_spray_count     <= '0;
      cfg_q.long_spray_count      <= '0;
      cfg_q.short_spray_delay_ms  <= '0;
      cfg_q.long_spray_delay_ms   <= '0;
    end else if (cfg_wr) begin
      unique case (reg_idx)
        REG_DETECT_TIMEOUT: cfg_q.detect_timeout_ms     <= pwdata;
        REG_SHORT_SIT:      cfg_q.short_sit_ms          <= pwdata;
        REG_LONG_SIT:       cfg_q.long_sit_ms           <= pwdata;
        REG_CLEAN_COUNT:    cfg_q.cleaning_motion_count <= pwdata[7:0];
        REG_SHORT_SPRAYS:   cfg_q.short_spray_count     <= pwdata[7:0];
        REG_LONG_SPRAYS:    cfg_q.long_spray_count      <= pwdata[7:0];
        REG_SHORT_DELAY:    cfg_q.short_spray_delay_ms  <= pwdata;
        REG_LONG_DELAY:     cfg_q.long_spray_delay_ms   <= pwdata;
        default: ;
      endcase
    end
  end

  always_comb begin
    unique case (reg_idx)
      REG_DETECT_TIMEOUT: prdata = cfg_q.detect_timeout_ms;
      REG_SHORT_SIT:      prdata = cfg_q.short_sit_ms;
      REG_LONG_SIT:       prdata = cfg_q.long_sit_ms;
      REG_CLEAN_COUNT:    prdata = {24'd0, cfg_q.cleaning_motion_count};
      REG_SHORT_SPRAYS:   prdata = {24'd0, cfg_q.short_spray_count};
      REG_LONG_SPRAYS:    prdata = {24'd0, cfg_q.long_spray_count};
      REG_SHORT_DELAY:    prdata = cfg_q.short_spray_delay_ms;
      REG_LONG_DELAY:     prdata = cfg_q.long_spray_delay_ms;
      default:            prdata = '0;
    endcase
  end

  // two-entry pipeline
  assign advance       = in_valid_q && (!out_valid_q || m_axis_tready);
  assign s_axis_tready = !in_valid_q || advance;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      in_valid_q  <= 1'b0;
      out_valid_q <= 1'b0;
    end else begin
      if (s_axis_tready) begin
        in_valid_q <= s_axis_tvalid;
      end
      if (advance) begin
        out_valid_q <= 1'b1;
      end else if (m_axis_tready) begin
        out_valid_q <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk_i) begin
    if (s_axis_tready && s_axis_tvalid) begin
      in_tick_q.time_ms       <= s_axis_tdata[31:0];
      in_tick_q.motion_seen   <= s_axis_tdata[32];
      in_tick_q.seat_occupied <= s_axis_tdata[33];
      in_tick_q.light_on      <= s_axis_tdata[34];
      in_tick_q.door_closed   <= s_axis_tdata[35];
      in_tick_q.motion_count  <= s_axis_tdata[43:36];
    end
    if (advance) begin
      out_res_q <= res;
    end
  end

  rucl_core u_core (
    .clk_i  (clk_i),
    .rst_ni (rst_ni),
    .step_i (advance),
    .tick_i (in_tick_q),
    .cfg_i  (cfg_q),
    .res_o  (res)
  );

  assign m_axis_tvalid = out_valid_q;
  assign m_axis_tdata  = {7'd0,
                          out_res_q.clear_motion_count,
                          out_res_q.wake_screen,
                          out_res_q.cancel_sprays,
                          out_res_q.spray_delay_ms,
                          out_res_q.spray_count,
                          out_res_q.spray_request,
                          out_res_q.green_led_mode,
                          out_res_q.room_state};

  // checks
  a_spray_ends_visit: assert property (@(posedge clk_i) disable iff (!rst_ni)
    m_axis_tvalid && out_res_q.spray_request |->
      out_res_q.clear_motion_count && (out_res_q.room_state == ROOM_IDLE))
    else $error("spray request without return to idle");

  a_detect_pulses: assert property (@(posedge clk_i) disable iff (!rst_ni)
    m_axis_tvalid && out_res_q.wake_screen |->
      out_res_q.cancel_sprays && (out_res_q.room_state == ROOM_DETECT))
    else $error("wake pulse without entry to detecting");

  a_held_tick_kept: assert property (@(posedge clk_i) disable iff (!rst_ni)
    in_valid_q && !advance |=> in_valid_q && $stable(in_tick_q))
    else $error("stalled tick lost from input register");

endmodule

`default_nettype wire

@@ test/room_use_checker.sv @@
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// room_use_checker
// Watches the tick stream, the result stream and the register port. Keeps its
// own copy of the visit state and registers, works out the result of every
// accepted tick, and compares each returned result field by field in order.
// ----------------------------------------------------------------------------
module room_use_checker
  import rucl_pkg::*;
(
  input  logic        clk_i,
  input  logic        rst_ni,
  input  logic        s_axis_tvalid,
  input  logic        s_axis_tready,
  input  logic [47:0] s_axis_tdata,
  input  logic        m_axis_tvalid,
  input  logic        m_axis_tready,
  input  logic [55:0] m_axis_tdata,
  input  logic        psel,
  input  logic        penable,
  input  logic        pwrite,
  input  logic [4:0]  paddr,
  input  logic [31:0] pwdata,
  input  logic        pready,
  output int          err_count_o,
  output int          pending_o,
  output int          checked_o,
  output int          sprays_o
);

  cfg_t        cfg;
  logic [2:0]  room_q;
  logic [1:0]  led_q;
  logic [31:0] entered_at;
  logic [31:0] sit_began;
  logic [31:0] max_sit;
  logic        on_seat;
  logic        got_up;
  logic        door_shut_at_sit;
  result_t     due_results[$];

  function automatic void move_to(input logic [2:0] nxt, input logic [31:0] now,
                                  inout result_t r);
    if (room_q != nxt) begin
      room_q = nxt;
      entered_at = now;
      case (nxt)
        ROOM_IDLE: begin
          r.clear_motion_count = 1'b1;
          on_seat = 1'b0;
          max_sit = '0;
          got_up = 1'b0;
          door_shut_at_sit = 1'b0;
          led_q = LED_SLOW_BLINK;
        end
        ROOM_DETECT: begin
          led_q = LED_FAST_BLINK;
          r.cancel_sprays = 1'b1;
          r.wake_screen = 1'b1;
        end
        ROOM_SHORT, ROOM_LONG: led_q = LED_OFF;
        default: led_q = LED_ON;
      endcase
    end
  endfunction

  function automatic result_t classify_tick(input tick_t t);
    result_t     r;
    logic [31:0] sat_for;
    logic [31:0] in_detect;
    r = '0;
    if (room_q == ROOM_IDLE) begin
      if (t.motion_seen && (t.light_on || !t.door_closed)) begin
        move_to(ROOM_DETECT, t.time_ms, r);
      end
    end else if (room_q == ROOM_DETECT) begin
      if (!on_seat && t.seat_occupied) begin
        got_up = 1'b0;
        sit_began = t.time_ms;
        on_seat = 1'b1;
        door_shut_at_sit = t.door_closed;
      end
      if (on_seat && !t.seat_occupied) begin
        sat_for = t.time_ms - sit_began;
        got_up = 1'b1;
        on_seat = 1'b0;
        if (sat_for > max_sit) max_sit = sat_for;
      end
      in_detect = t.time_ms - entered_at;
      if ((!t.light_on && !t.motion_seen && got_up) ||
          in_detect >= cfg.detect_timeout_ms) begin
        if (t.motion_count >= cfg.cleaning_motion_count && !door_shut_at_sit) begin
          move_to(ROOM_CLEAN, t.time_ms, r);
        end else if (max_sit < cfg.long_sit_ms && max_sit > cfg.short_sit_ms) begin
          move_to(ROOM_SHORT, t.time_ms, r);
        end else if (max_sit > cfg.long_sit_ms) begin
          move_to(ROOM_LONG, t.time_ms, r);
        end else begin
          move_to(ROOM_IDLE, t.time_ms, r);
        end
      end
    end else if (room_q == ROOM_SHORT || room_q == ROOM_LONG || room_q == ROOM_CLEAN) begin
      if (!t.motion_seen && !t.seat_occupied && (!t.light_on || t.door_closed)) begin
        if (room_q == ROOM_SHORT) begin
          r.spray_request = 1'b1;
          r.spray_count = cfg.short_spray_count;
          r.spray_delay_ms = cfg.short_spray_delay_ms;
        end else if (room_q == ROOM_LONG) begin
          r.spray_request = 1'b1;
          r.spray_count = cfg.long_spray_count;
          r.spray_delay_ms = cfg.long_spray_delay_ms;
        end
        move_to(ROOM_IDLE, t.time_ms, r);
      end
    end
    r.room_state = room_q;
    r.green_led_mode = led_q;
    return r;
  endfunction

  function automatic void check_field(input string name, input logic [31:0] want,
                                      input logic [31:0] got);
    if (got !== want) begin
      if (err_count_o < 10) begin
        $display("%0t ns: %s mismatch, expected %0h, got %0h", $time, name, want, got);
      end
      err_count_o++;
    end
  endfunction

  always @(posedge clk_i or negedge rst_ni) begin
    result_t want;
    result_t got;
    tick_t   t;
    if (!rst_ni) begin
      cfg = '0;
      cfg.detect_timeout_ms = RST_DETECT_TIMEOUT;
      cfg.short_sit_ms = RST_SHORT_SIT;
      cfg.long_sit_ms = RST_LONG_SIT;
      cfg.cleaning_motion_count = RST_CLEAN_COUNT;
      room_q = ROOM_IDLE;
      led_q = LED_SLOW_BLINK;
      entered_at = '0;
      sit_began = '0;
      max_sit = '0;
      on_seat = 1'b0;
      got_up = 1'b0;
      door_shut_at_sit = 1'b0;
      due_results.delete();
      err_count_o = 0;
      pending_o = 0;
      checked_o = 0;
      sprays_o = 0;
    end else begin
      if (m_axis_tvalid && m_axis_tready) begin
        got.room_state = m_axis_tdata[2:0];
        got.green_led_mode = m_axis_tdata[4:3];
        got.spray_request = m_axis_tdata[5];
        got.spray_count = m_axis_tdata[13:6];
        got.spray_delay_ms = m_axis_tdata[45:14];
        got.cancel_sprays = m_axis_tdata[46];
        got.wake_screen = m_axis_tdata[47];
        got.clear_motion_count = m_axis_tdata[48];
        if (due_results.size() == 0) begin
          if (err_count_o < 10) begin
            $display("%0t ns: result %0h with no tick waiting", $time, m_axis_tdata);
          end
          err_count_o++;
        end else begin
          want = due_results.pop_front();
          check_field("room_state", 32'(want.room_state), 32'(got.room_state));
          check_field("green_led_mode", 32'(want.green_led_mode), 32'(got.green_led_mode));
          check_field("spray_request", 32'(want.spray_request), 32'(got.spray_request));
          check_field("spray_count", 32'(want.spray_count), 32'(got.spray_count));
          check_field("spray_delay_ms", want.spray_delay_ms, got.spray_delay_ms);
          check_field("cancel_sprays", 32'(want.cancel_sprays), 32'(got.cancel_sprays));
          check_field("wake_screen", 32'(want.wake_screen), 32'(got.wake_screen));
          check_field("clear_motion_count", 32'(want.clear_motion_count),
                      32'(got.clear_motion_count));
          checked_o++;
          if (want.spray_request) sprays_o++;
        end
      end
      if (psel && penable && pwrite && pready) begin
        case (paddr[4:2])
          REG_DETECT_TIMEOUT: cfg.detect_timeout_ms = pwdata;
          REG_SHORT_SIT:      cfg.short_sit_ms = pwdata;
          REG_LONG_SIT:       cfg.long_sit_ms = pwdata;
          REG_CLEAN_COUNT:    cfg.cleaning_motion_count = pwdata[7:0];
          REG_SHORT_SPRAYS:   cfg.short_spray_count = pwdata[7:0];
          REG_LONG_SPRAYS:    cfg.long_spray_count = pwdata[7:0];
          REG_SHORT_DELAY:    cfg.short_spray_delay_ms = pwdata;
          REG_LONG_DELAY:     cfg.long_spray_delay_ms = pwdata;
          default: ;
        endcase
      end
      if (s_axis_tvalid && s_axis_tready) begin
        t.time_ms = s_axis_tdata[31:0];
        t.motion_seen = s_axis_tdata[32];
        t.seat_occupied = s_axis_tdata[33];
        t.light_on = s_axis_tdata[34];
        t.door_closed = s_axis_tdata[35];
        t.motion_count = s_axis_tdata[43:36];
        due_results.push_back(classify_tick(t));
      end
      pending_o = due_results.size();
    end
  end

endmodule

@@ test/tb_room_use_classifier_top.sv @@
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// tb_room_use_classifier_top
// Drives sensor ticks into the room use classifier: a directed walk through
// every visit kind, then random visits under several register settings and
// idling patterns. A separate checker predicts and compares every result.
// ----------------------------------------------------------------------------
module tb_room_use_classifier_top;
  import rucl_pkg::*;

  localparam int HOLD_CYCLES = 60;
  localparam int PHASE_TICKS = 280;

  logic        clk_i = 1'b0;
  logic        rst_ni = 1'b0;
  logic        s_axis_tvalid = 1'b0;
  logic        s_axis_tready;
  // tdata: time_ms[31:0], motion_seen[32], seat_occupied[33], light_on[34],
  //        door_closed[35], motion_count[43:36], zero[47:44]
  logic [47:0] s_axis_tdata = '0;
  logic        m_axis_tvalid;
  logic        m_axis_tready = 1'b0;
  // tdata: room_state[2:0], green_led_mode[4:3], spray_request[5],
  //        spray_count[13:6], spray_delay_ms[45:14], cancel_sprays[46],
  //        wake_screen[47], clear_motion_count[48], zero[55:49]
  logic [55:0] m_axis_tdata;
  logic        psel = 1'b0;
  logic        penable = 1'b0;
  logic        pwrite = 1'b0;
  logic [4:0]  paddr = '0;
  logic [31:0] pwdata = '0;
  logic [31:0] prdata;
  logic        pready;

  int          err_count;
  int          pending;
  int          checked;
  int          sprays;

  int          send_idle_pct = 0;
  int          stall_pct = 0;
  int          burst_left = 0;
  logic        hold_go = 1'b0;
  logic [31:0] now_ms;
  cfg_t        cfg_now;
  int          ticks_sent = 0;
  int          phase_ticks = 0;
  int          settings_n = 1;

  always #2 clk_i = ~clk_i;

  room_use_classifier_top i_dut (
    .clk_i         (clk_i),
    .rst_ni        (rst_ni),
    .s_axis_tvalid (s_axis_tvalid),
    .s_axis_tready (s_axis_tready),
    .s_axis_tdata  (s_axis_tdata),
    .m_axis_tvalid (m_axis_tvalid),
    .m_axis_tready (m_axis_tready),
    .m_axis_tdata  (m_axis_tdata),
    .psel          (psel),
    .penable       (penable),
    .pwrite        (pwrite),
    .paddr         (paddr),
    .pwdata        (pwdata),
    .prdata        (prdata),
    .pready        (pready)
  );

  room_use_checker i_checker (
    .clk_i         (clk_i),
    .rst_ni        (rst_ni),
    .s_axis_tvalid (s_axis_tvalid),
    .s_axis_tready (s_axis_tready),
    .s_axis_tdata  (s_axis_tdata),
    .m_axis_tvalid (m_axis_tvalid),
    .m_axis_tready (m_axis_tready),
    .m_axis_tdata  (m_axis_tdata),
    .psel          (psel),
    .penable       (penable),
    .pwrite        (pwrite),
    .paddr         (paddr),
    .pwdata        (pwdata),
    .pready        (pready),
    .err_count_o   (err_count),
    .pending_o     (pending),
    .checked_o     (checked),
    .sprays_o      (sprays)
  );

  // result side: random stalls, plus a long hold-off on request
  initial begin
    forever begin
      @(posedge clk_i);
      if (hold_go) begin
        hold_go = 1'b0;
        m_axis_tready <= 1'b0;
        repeat (HOLD_CYCLES) @(posedge clk_i);
      end
      m_axis_tready <= ($urandom_range(99) >= stall_pct);
    end
  end

  initial begin
    #2_000_000;
    $display("FAIL");
    $finish;
  end

  function automatic logic rbit();
    return 1'($urandom_range(1));
  endfunction

  task automatic write_reg(input logic [2:0] idx, input logic [31:0] val);
    psel <= 1'b1;
    penable <= 1'b0;
    pwrite <= 1'b1;
    paddr <= {idx, 2'b00};
    pwdata <= val;
    @(posedge clk_i);
    penable <= 1'b1;
    do @(posedge clk_i); while (!pready);
    psel <= 1'b0;
    penable <= 1'b0;
    pwrite <= 1'b0;
    @(posedge clk_i);
  endtask

  task automatic load_cfg(input cfg_t c);
    write_reg(REG_DETECT_TIMEOUT, c.detect_timeout_ms);
    write_reg(REG_SHORT_SIT, c.short_sit_ms);
    write_reg(REG_LONG_SIT, c.long_sit_ms);
    write_reg(REG_CLEAN_COUNT, {24'($urandom), c.cleaning_motion_count});
    write_reg(REG_SHORT_SPRAYS, {24'($urandom), c.short_spray_count});
    write_reg(REG_LONG_SPRAYS, {24'($urandom), c.long_spray_count});
    write_reg(REG_SHORT_DELAY, c.short_spray_delay_ms);
    write_reg(REG_LONG_DELAY, c.long_spray_delay_ms);
    cfg_now = c;
  endtask

  function automatic cfg_t phase_cfg(input int p);
    cfg_t c;
    c.short_spray_count = 8'($urandom);
    c.long_spray_count = 8'($urandom);
    c.short_spray_delay_ms = $urandom;
    c.long_spray_delay_ms = $urandom;
    c.cleaning_motion_count = 8'($urandom_range(1, 30));
    case (p)
      0: begin
        c.detect_timeout_ms = RST_DETECT_TIMEOUT;
        c.short_sit_ms = RST_SHORT_SIT;
        c.long_sit_ms = RST_LONG_SIT;
        c.cleaning_motion_count = RST_CLEAN_COUNT;
      end
      1: c = '1;
      2: c = '0;
      3: begin
        c.detect_timeout_ms = $urandom_range(2000, 8000);
        c.short_sit_ms = 32'd100;
        c.long_sit_ms = 32'd1000;
      end
      4: begin
        c.detect_timeout_ms = $urandom;
        c.short_sit_ms = $urandom_range(50000);
        c.long_sit_ms = c.short_sit_ms + $urandom_range(200000);
      end
      default: begin
        c.detect_timeout_ms = 32'd50000;
        c.short_sit_ms = 32'd20000;
        c.long_sit_ms = 32'd40000;
        c.cleaning_motion_count = 8'd1;
      end
    endcase
    return c;
  endfunction

  task automatic set_idling(input int m);
    case (m)
      0: begin send_idle_pct = 0; stall_pct = 0; end
      1: begin send_idle_pct = 75; stall_pct = 0; end
      2: begin send_idle_pct = 0; stall_pct = 75; end
      default: begin send_idle_pct = 7; stall_pct = 7; end
    endcase
  endtask

  task automatic put(input logic [31:0] tm, input logic mo, input logic st,
                     input logic li, input logic dc, input logic [7:0] mc);
    logic [63:0] junk;
    if (burst_left > 0) begin
      burst_left--;
    end else begin
      while ($urandom_range(99) < send_idle_pct) begin
        junk = {$urandom, $urandom};
        s_axis_tvalid <= 1'b0;
        s_axis_tdata <= junk[47:0];
        @(posedge clk_i);
      end
    end
    s_axis_tvalid <= 1'b1;
    s_axis_tdata <= {4'b0000, mc, dc, li, st, mo, tm};
    do @(posedge clk_i); while (!s_axis_tready);
    ticks_sent++;
    phase_ticks++;
  endtask

  task automatic drain();
    s_axis_tvalid <= 1'b0;
    @(posedge clk_i);
    while (pending != 0) @(posedge clk_i);
  endtask

  task automatic advance();
    now_ms += $urandom_range(1, 3000);
  endtask

  function automatic logic [7:0] pick_count();
    case ($urandom_range(3))
      0: return cfg_now.cleaning_motion_count - 8'd1;
      1: return cfg_now.cleaning_motion_count;
      2: return 8'($urandom);
      default: return 8'd0;
    endcase
  endfunction

  function automatic logic [31:0] pick_sit();
    logic [31:0] gap;
    gap = cfg_now.long_sit_ms - cfg_now.short_sit_ms;
    case ($urandom_range(7))
      0: return cfg_now.short_sit_ms - 32'd1 + $urandom_range(2);
      1: return cfg_now.long_sit_ms - 32'd1 + $urandom_range(2);
      2: return (gap > 32'd1) ? cfg_now.short_sit_ms + 32'd1 + ($urandom % (gap - 32'd1))
                              : $urandom;
      3: return $urandom_range(20000);
      4: return cfg_now.long_sit_ms + $urandom_range(1, 1000);
      5: return $urandom;
      6: return 32'd0;
      default: return cfg_now.short_sit_ms + $urandom_range(1, 500);
    endcase
  endfunction

  // one visit: enter, one or two sittings or a wait to the detect timeout, decision, stay, leave
  task automatic run_visit();
    logic        li;
    logic [31:0] t0;
    if ($urandom_range(19) == 0) now_ms = $urandom;
    repeat ($urandom_range(2)) begin
      advance();
      put(now_ms, $urandom_range(3) == 0, rbit(), rbit(), rbit(), 8'($urandom));
    end
    li = rbit();
    advance();
    put(now_ms, 1'b1, 1'b0, li, li & rbit(), 8'($urandom_range(20)));
    t0 = now_ms;
    if ($urandom_range(7) == 0) begin
      now_ms = t0 + cfg_now.detect_timeout_ms - 32'd1 + $urandom_range(2);
      put(now_ms, rbit(), 1'b0, 1'b1, rbit(), pick_count());
    end else begin
      repeat ($urandom_range(2)) begin
        advance();
        put(now_ms, rbit(), 1'b0, 1'b1, rbit(), pick_count());
      end
      repeat ($urandom_range(1, 2)) begin
        advance();
        t0 = now_ms;
        put(now_ms, rbit(), 1'b1, 1'b1, rbit(), pick_count());
        repeat ($urandom_range(2)) begin
          now_ms += $urandom_range(1, 50);
          put(now_ms, rbit(), 1'b1, rbit(), rbit(), 8'($urandom));
        end
        now_ms = t0 + pick_sit();
        put(now_ms, rbit(), 1'b0, 1'b1, rbit(), pick_count());
      end
      if ($urandom_range(9) != 0) begin
        advance();
        put(now_ms, 1'b0, 1'b0, 1'b0, rbit(), pick_count());
      end
    end
    repeat ($urandom_range(2)) begin
      advance();
      put(now_ms, 1'b1, rbit(), rbit(), rbit(), 8'($urandom));
    end
    li = rbit();
    advance();
    put(now_ms, 1'b0, 1'b0, li, li | rbit(), 8'($urandom));
  endtask

  initial begin
    logic held;
    logic paused;
    repeat (10) @(posedge clk_i);
    rst_ni <= 1'b1;
    @(posedge clk_i);
    cfg_now = '0;
    cfg_now.detect_timeout_ms = RST_DETECT_TIMEOUT;
    cfg_now.short_sit_ms = RST_SHORT_SIT;
    cfg_now.long_sit_ms = RST_LONG_SIT;
    cfg_now.cleaning_motion_count = RST_CLEAN_COUNT;

    // directed walk at reset register values
    put(32'h0000_0000, 1'b0, 1'b0, 1'b0, 1'b0, 8'h00);
    put(32'hFFFF_FFFF, 1'b1, 1'b1, 1'b0, 1'b1, 8'hFF);
    put(32'hFFFF_FF00, 1'b1, 1'b0, 1'b0, 1'b0, 8'h00);
    put(32'hFFFF_FF08, 1'b0, 1'b0, 1'b0, 1'b1, 8'h00);
    put(32'hFFFF_FF10, 1'b1, 1'b1, 1'b1, 1'b1, 8'h03);
    put(32'h0000_C000, 1'b1, 1'b0, 1'b1, 1'b1, 8'h03);
    put(32'h0000_C010, 1'b0, 1'b0, 1'b0, 1'b1, 8'hFF);
    put(32'h0000_C020, 1'b1, 1'b0, 1'b0, 1'b1, 8'h00);
    put(32'h0000_C030, 1'b0, 1'b0, 1'b1, 1'b0, 8'h00);
    put(32'h0000_C040, 1'b0, 1'b0, 1'b1, 1'b1, 8'h00);
    put(32'h0000_D000, 1'b1, 1'b0, 1'b1, 1'b1, 8'h00);
    put(32'h0000_D001, 1'b0, 1'b1, 1'b1, 1'b0, 8'h00);
    put(32'h0002_56A2, 1'b0, 1'b0, 1'b1, 1'b0, 8'h00);
    put(32'h0002_56B0, 1'b0, 1'b0, 1'b0, 1'b0, 8'd11);
    put(32'h0002_56C0, 1'b0, 1'b0, 1'b0, 1'b0, 8'h00);
    put(32'h0002_0000, 1'b1, 1'b0, 1'b1, 1'b0, 8'h00);
    put(32'h0002_0010, 1'b0, 1'b1, 1'b1, 1'b0, 8'h00);
    put(32'h0002_0042, 1'b0, 1'b0, 1'b1, 1'b0, 8'h00);
    put(32'h0002_0050, 1'b0, 1'b0, 1'b0, 1'b0, 8'd12);
    put(32'h0002_0060, 1'b0, 1'b0, 1'b0, 1'b1, 8'h00);
    put(32'h0003_0000, 1'b1, 1'b0, 1'b1, 1'b1, 8'h00);
    put(32'h0003_0001, 1'b0, 1'b1, 1'b1, 1'b1, 8'h00);
    put(32'h0004_86A1, 1'b0, 1'b0, 1'b1, 1'b1, 8'h00);
    put(32'h0004_86B0, 1'b0, 1'b0, 1'b0, 1'b1, 8'h00);
    put(32'h0005_0000, 1'b1, 1'b0, 1'b1, 1'b1, 8'h00);
    put(32'h0007_BF20, 1'b1, 1'b0, 1'b1, 1'b1, 8'h00);
    drain();

    now_ms = 32'hFFF0_0000;
    for (int p = 0; p < 6; p++) begin
      load_cfg(phase_cfg(p));
      settings_n++;
      set_idling(p % 4);
      phase_ticks = 0;
      held = 1'b0;
      paused = 1'b0;
      while (phase_ticks < PHASE_TICKS) begin
        if (!held && phase_ticks >= 60) begin
          held = 1'b1;
          hold_go = 1'b1;
          burst_left = 30;
        end
        if (!paused && phase_ticks >= 160) begin
          paused = 1'b1;
          drain();
        end
        run_visit();
      end
      drain();
    end
    repeat (20) @(posedge clk_i);

    $display("covered %0d ticks under %0d register settings and four idling patterns",
             ticks_sent, settings_n);
    $display("checked %0d results, %0d of them spray requests", checked, sprays);
    if (err_count == 0) begin
      $display("PASS");
    end else begin
      $display("FAIL");
    end
    $finish;
  end

endmodule
